>>> hw/rtl/dmc_pkg.sv
// shared types, codes and constants for the maze carver
// no dependencies
`default_nettype none

package dmc_pkg;

    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;
    localparam int COORD_LIMIT  = 64;

    localparam int COORD_W   = 6;
    localparam int SIZE_W    = 7;
    localparam int CMD_W     = 2;
    localparam int DIR_W     = 2;
    localparam int STATUS_W  = 3;
    localparam int DIRSET_W  = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [COORD_W-1:0]  START_POS = 6'd1;
    localparam logic [COORD_W-1:0]  STEP_LEN  = 6'd2;
    localparam logic [DIRSET_W-1:0] ALL_DIRS  = 4'd15;
    localparam logic [SIZE_W-1:0]   GRID_RESET = 7'd64;

    localparam logic [CMD_W-1:0] CMD_INIT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STEP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd0;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_UP    = 2'd3;
    localparam logic [DIR_W-1:0] DIR_FLIP  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INIT_DONE   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EXPLORED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BLOCKED     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CARVED      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BACKTRACKED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FINISHED    = 3'd5;
    localparam logic [STATUS_W-1:0] ST_READ_DATA   = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_STEP,
        S_READ,
        S_RESP
    } state_t;

    typedef struct packed {
        logic capture;
        logic init_write;
        logic eval_step;
        logic eval_read;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic sweep_last;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/dmc_ctrl.sv
// sequencing state machine for the maze carver
// depends on dmc_pkg
`default_nettype none

module dmc_ctrl
    import dmc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [CMD_W-1:0] command,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output dp_cmd_t               dp_cmd,
    input  wire dp_stat_t         dp_stat
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        dp_cmd     = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    dp_cmd.capture = 1'b1;
                    case (command)
                        CMD_INIT: state_next = S_INIT;
                        CMD_STEP: state_next = S_STEP;
                        CMD_READ: state_next = S_READ;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_INIT:
            begin
                dp_cmd.init_write = 1'b1;
                if (dp_stat.sweep_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_STEP:
            begin
                dp_cmd.eval_step = 1'b1;
                state_next       = S_RESP;
            end
            S_READ:
            begin
                dp_cmd.eval_read = 1'b1;
                state_next       = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    dp_cmd.load_out = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (dp_cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> hw/rtl/dmc_datapath.sv
// grid memories, current node, size registers and result registers
// depends on dmc_pkg
`default_nettype none

module dmc_datapath
    import dmc_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dp_cmd_t              dp_cmd,
    output dp_stat_t                  dp_stat,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SIZE_W-1:0]    cfg_data,
    input  wire logic [CMD_W-1:0]     command,
    input  wire logic [DIR_W-1:0]     random_dir,
    input  wire logic [COORD_W-1:0]   read_col,
    input  wire logic [COORD_W-1:0]   read_row,
    output logic [STATUS_W-1:0]       status,
    output logic [COORD_W-1:0]        cell_col,
    output logic [COORD_W-1:0]        cell_row,
    output logic                      cell_open
);

    localparam int STORE_COLS = (MAX_COLS < COORD_LIMIT) ? MAX_COLS : COORD_LIMIT;
    localparam int STORE_ROWS = (MAX_ROWS < COORD_LIMIT) ? MAX_ROWS : COORD_LIMIT;
    localparam int CW         = $clog2(STORE_COLS);
    localparam int RW         = $clog2(STORE_ROWS);
    localparam int AW         = CW + RW;
    localparam int DEPTH      = 1 << AW;

    localparam logic [SIZE_W-1:0] STORE_COLS_V = SIZE_W'(STORE_COLS);
    localparam logic [SIZE_W-1:0] STORE_ROWS_V = SIZE_W'(STORE_ROWS);

    function automatic logic [AW-1:0] cell_addr(input logic [COORD_W-1:0] c,
                                                input logic [COORD_W-1:0] r);
        cell_addr = {r[RW-1:0], c[CW-1:0]};
    endfunction

    function automatic logic in_store(input logic [COORD_W-1:0] c,
                                      input logic [COORD_W-1:0] r);
        in_store = ({1'b0, c} < STORE_COLS_V) && ({1'b0, r} < STORE_ROWS_V);
    endfunction

    logic                open_mem   [DEPTH];
    logic [DIRSET_W-1:0] dirs_mem   [DEPTH];
    logic [DIR_W-1:0]    back_mem   [DEPTH];
    logic                linked_mem [DEPTH];

    logic                open_q;
    logic [DIRSET_W-1:0] dirs_q;
    logic [DIR_W-1:0]    back_q;
    logic                linked_q;

    logic [SIZE_W-1:0]   grid_cols_reg;
    logic [SIZE_W-1:0]   grid_rows_reg;
    logic [COORD_W-1:0]  cur_col_reg;
    logic [COORD_W-1:0]  cur_col_next;
    logic [COORD_W-1:0]  cur_row_reg;
    logic [COORD_W-1:0]  cur_row_next;
    logic                finished_reg;
    logic                finished_next;
    logic [AW-1:0]       sweep_reg;

    logic [DIR_W-1:0]    dir_reg;
    logic [COORD_W-1:0]  rd_col_reg;
    logic [COORD_W-1:0]  rd_row_reg;
    logic                rd_in_reg;
    logic [COORD_W-1:0]  dst_col_reg;
    logic [COORD_W-1:0]  dst_row_reg;
    logic                dst_ok_reg;

    logic [STATUS_W-1:0] res_status_reg;
    logic [STATUS_W-1:0] res_status_next;
    logic [COORD_W-1:0]  res_col_reg;
    logic [COORD_W-1:0]  res_col_next;
    logic [COORD_W-1:0]  res_row_reg;
    logic [COORD_W-1:0]  res_row_next;
    logic                res_open_reg;
    logic                res_open_next;

    logic [STATUS_W-1:0] out_status_reg;
    logic [COORD_W-1:0]  out_col_reg;
    logic [COORD_W-1:0]  out_row_reg;
    logic                out_open_reg;

    logic [SIZE_W-1:0]   eff_cols;
    logic [SIZE_W-1:0]   eff_rows;
    logic                cur_in;

    logic [SIZE_W-1:0]   step_col;
    logic [SIZE_W-1:0]   step_row;
    logic [COORD_W-1:0]  dst_col;
    logic [COORD_W-1:0]  dst_row;
    logic                dst_ok;
    logic [AW-1:0]       rd_b_addr;

    logic [DIRSET_W-1:0] dirs_eff;
    logic [DIR_W-1:0]    back_eff;
    logic [DIRSET_W-1:0] dir_bit;
    logic [COORD_W-1:0]  bt_col;
    logic [COORD_W-1:0]  bt_row;
    logic [SIZE_W-1:0]   wall_col_sum;
    logic [SIZE_W-1:0]   wall_row_sum;
    logic [COORD_W-1:0]  wall_col;
    logic [COORD_W-1:0]  wall_row;

    logic [COORD_W-1:0]  sw_col;
    logic [COORD_W-1:0]  sw_row;
    logic                sw_inside;

    logic                open_we;
    logic [AW-1:0]       open_wa;
    logic                open_wd;
    logic                dirs_we;
    logic [AW-1:0]       dirs_wa;
    logic [DIRSET_W-1:0] dirs_wd;
    logic                back_we;
    logic [AW-1:0]       back_wa;
    logic [DIR_W-1:0]    back_wd;
    logic                link_we;
    logic [AW-1:0]       link_wa;
    logic                link_wd;

    assign eff_cols = (grid_cols_reg > STORE_COLS_V) ? STORE_COLS_V : grid_cols_reg;
    assign eff_rows = (grid_rows_reg > STORE_ROWS_V) ? STORE_ROWS_V : grid_rows_reg;
    assign cur_in   = in_store(cur_col_reg, cur_row_reg);

    // destination of a step, from the current node and the offered direction
    always_comb
    begin
        step_col = {1'b0, cur_col_reg};
        step_row = {1'b0, cur_row_reg};
        dst_ok   = 1'b0;
        case (random_dir)
            DIR_RIGHT:
            begin
                step_col = {1'b0, cur_col_reg} + {1'b0, STEP_LEN};
                dst_ok   = step_col < eff_cols;
            end
            DIR_DOWN:
            begin
                step_row = {1'b0, cur_row_reg} + {1'b0, STEP_LEN};
                dst_ok   = step_row < eff_rows;
            end
            DIR_LEFT:
            begin
                step_col = {1'b0, cur_col_reg} - {1'b0, STEP_LEN};
                dst_ok   = cur_col_reg >= STEP_LEN;
            end
            DIR_UP:
            begin
                step_row = {1'b0, cur_row_reg} - {1'b0, STEP_LEN};
                dst_ok   = cur_row_reg >= STEP_LEN;
            end
            default:
            begin
                dst_ok = 1'b0;
            end
        endcase
    end

    assign dst_col   = step_col[COORD_W-1:0];
    assign dst_row   = step_row[COORD_W-1:0];
    assign rd_b_addr = (command == CMD_READ) ? cell_addr(read_col, read_row)
                                             : cell_addr(dst_col, dst_row);

    // grid memories
    always_ff @(posedge clk)
    begin
        open_q   <= open_mem[rd_b_addr];
        linked_q <= linked_mem[rd_b_addr];
        dirs_q   <= dirs_mem[cell_addr(cur_col_reg, cur_row_reg)];
        back_q   <= back_mem[cell_addr(cur_col_reg, cur_row_reg)];
        if (open_we)
        begin
            open_mem[open_wa] <= open_wd;
        end
        if (link_we)
        begin
            linked_mem[link_wa] <= link_wd;
        end
        if (dirs_we)
        begin
            dirs_mem[dirs_wa] <= dirs_wd;
        end
        if (back_we)
        begin
            back_mem[back_wa] <= back_wd;
        end
    end

    assign sw_col    = COORD_W'(sweep_reg[CW-1:0]);
    assign sw_row    = COORD_W'(sweep_reg[AW-1:CW]);
    assign sw_inside = ({1'b0, sw_col} < eff_cols) && ({1'b0, sw_row} < eff_rows);
    assign dp_stat.sweep_last = (sweep_reg == AW'(DEPTH - 1));

    assign dirs_eff     = cur_in ? dirs_q : '0;
    assign back_eff     = cur_in ? back_q : '0;
    assign dir_bit      = DIRSET_W'(1) << dir_reg;
    assign wall_col_sum = {1'b0, cur_col_reg} + {1'b0, dst_col_reg};
    assign wall_row_sum = {1'b0, cur_row_reg} + {1'b0, dst_row_reg};
    assign wall_col     = wall_col_sum[SIZE_W-1:1];
    assign wall_row     = wall_row_sum[SIZE_W-1:1];

    // parent node for a backtrack
    always_comb
    begin
        bt_col = cur_col_reg;
        bt_row = cur_row_reg;
        if (!(cur_col_reg == START_POS && cur_row_reg == START_POS))
        begin
            case (back_eff)
                DIR_RIGHT: bt_col = cur_col_reg + STEP_LEN;
                DIR_DOWN:  bt_row = cur_row_reg + STEP_LEN;
                DIR_LEFT:  bt_col = cur_col_reg - STEP_LEN;
                default:   bt_row = cur_row_reg - STEP_LEN;
            endcase
        end
    end

    always_comb
    begin
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        finished_next   = finished_reg;
        res_status_next = res_status_reg;
        res_col_next    = res_col_reg;
        res_row_next    = res_row_reg;
        res_open_next   = res_open_reg;
        open_we = 1'b0;
        open_wa = cell_addr(wall_col, wall_row);
        open_wd = 1'b1;
        dirs_we = 1'b0;
        dirs_wa = cell_addr(cur_col_reg, cur_row_reg);
        dirs_wd = dirs_eff & ~dir_bit;
        back_we = 1'b0;
        back_wa = cell_addr(dst_col_reg, dst_row_reg);
        back_wd = dir_reg ^ DIR_FLIP;
        link_we = 1'b0;
        link_wa = cell_addr(dst_col_reg, dst_row_reg);
        link_wd = 1'b1;
        if (dp_cmd.init_write)
        begin
            open_we = 1'b1;
            open_wa = sweep_reg;
            open_wd = sw_inside && sw_col[0] && sw_row[0];
            dirs_we = 1'b1;
            dirs_wa = sweep_reg;
            dirs_wd = ALL_DIRS;
            back_we = 1'b1;
            back_wa = sweep_reg;
            back_wd = '0;
            link_we = 1'b1;
            link_wa = sweep_reg;
            link_wd = (sw_col == START_POS) && (sw_row == START_POS);
            if (dp_stat.sweep_last)
            begin
                cur_col_next    = START_POS;
                cur_row_next    = START_POS;
                finished_next   = 1'b0;
                res_status_next = ST_INIT_DONE;
                res_col_next    = START_POS;
                res_row_next    = START_POS;
                res_open_next   = 1'b0;
            end
        end
        else if (dp_cmd.eval_read)
        begin
            res_status_next = ST_READ_DATA;
            res_col_next    = rd_col_reg;
            res_row_next    = rd_row_reg;
            res_open_next   = rd_in_reg && open_q;
        end
        else if (dp_cmd.eval_step)
        begin
            res_open_next   = 1'b0;
            res_col_next    = cur_col_reg;
            res_row_next    = cur_row_reg;
            if (finished_reg)
            begin
                res_status_next = ST_FINISHED;
            end
            else if (dirs_eff == '0)
            begin
                if (bt_col == START_POS && bt_row == START_POS)
                begin
                    finished_next   = 1'b1;
                    cur_col_next    = START_POS;
                    cur_row_next    = START_POS;
                    res_status_next = ST_FINISHED;
                    res_col_next    = START_POS;
                    res_row_next    = START_POS;
                end
                else
                begin
                    cur_col_next    = bt_col;
                    cur_row_next    = bt_row;
                    res_status_next = ST_BACKTRACKED;
                    res_col_next    = bt_col;
                    res_row_next    = bt_row;
                end
            end
            else if ((dirs_eff & dir_bit) == '0)
            begin
                res_status_next = ST_EXPLORED;
            end
            else
            begin
                dirs_we = 1'b1;
                if (!dst_ok_reg || !open_q || linked_q)
                begin
                    res_status_next = ST_BLOCKED;
                end
                else
                begin
                    link_we         = 1'b1;
                    back_we         = 1'b1;
                    open_we         = 1'b1;
                    cur_col_next    = dst_col_reg;
                    cur_row_next    = dst_row_reg;
                    res_status_next = ST_CARVED;
                    res_col_next    = wall_col;
                    res_row_next    = wall_row;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg <= GRID_RESET;
            grid_rows_reg <= GRID_RESET;
            cur_col_reg   <= START_POS;
            cur_row_reg   <= START_POS;
            finished_reg  <= 1'b0;
            sweep_reg     <= '0;
        end
        else
        begin
            if (cfg_write && cfg_index == CFG_GRID_COLS)
            begin
                grid_cols_reg <= cfg_data;
            end
            if (cfg_write && cfg_index == CFG_GRID_ROWS)
            begin
                grid_rows_reg <= cfg_data;
            end
            cur_col_reg  <= cur_col_next;
            cur_row_reg  <= cur_row_next;
            finished_reg <= finished_next;
            if (dp_cmd.init_write)
            begin
                sweep_reg <= sweep_reg + AW'(1);
            end
        end
    end

    // payload, result and output registers
    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            dir_reg     <= random_dir;
            rd_col_reg  <= read_col;
            rd_row_reg  <= read_row;
            rd_in_reg   <= in_store(read_col, read_row);
            dst_col_reg <= dst_col;
            dst_row_reg <= dst_row;
            dst_ok_reg  <= dst_ok && in_store(dst_col, dst_row);
        end
        res_status_reg <= res_status_next;
        res_col_reg    <= res_col_next;
        res_row_reg    <= res_row_next;
        res_open_reg   <= res_open_next;
        if (dp_cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_col_reg    <= res_col_reg;
            out_row_reg    <= res_row_reg;
            out_open_reg   <= res_open_reg;
        end
    end

    assign status    = out_status_reg;
    assign cell_col  = out_col_reg;
    assign cell_row  = out_row_reg;
    assign cell_open = out_open_reg;

endmodule

`default_nettype wire

>>> hw/rtl/dfs_maze_carver_unit.sv
// top level of the depth-first maze carver: controller plus datapath
// depends on dmc_pkg, dmc_ctrl, dmc_datapath
//
// usage
//   input channel (in_valid/in_ready) carries command, random_dir, read_col,
//   read_row; each init, step or read transaction gives exactly one result
//   transaction on the output channel (out_valid/out_ready) with status,
//   cell_col, cell_row and cell_open. command 3 is taken and dropped.
//   config channel (cfg_valid/cfg_ready), always ready, writes grid_cols
//   (index 0) and grid_rows (index 1); use it only while idle (unenforced).
// timing
//   step and read: each transaction is accepted with memory read, evaluated
//   with memory write and handed off to the output register; the next one is
//   accepted only after the hand-off.
//   init: one cell written per cycle over the whole grid store,
//   2^(clog2 cols + clog2 rows) cells, 4096 at the default size.
// reset
//   current node (1,1), not finished, grid size 64 x 64; grid contents are
//   undefined until the first init.
// stall
//   a result waits in the output register; the next transaction is accepted
//   and evaluated, and its result waits until the output register frees.
`default_nettype none

module dfs_maze_carver_unit
    import dmc_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [CMD_W-1:0]     command,
    input  wire logic [DIR_W-1:0]     random_dir,
    input  wire logic [COORD_W-1:0]   read_col,
    input  wire logic [COORD_W-1:0]   read_row,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [STATUS_W-1:0]       status,
    output logic [COORD_W-1:0]        cell_col,
    output logic [COORD_W-1:0]        cell_row,
    output logic                      cell_open,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SIZE_W-1:0]    cfg_data
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    assign cfg_ready = 1'b1;

    dmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_cmd    (dp_cmd),
        .dp_stat   (dp_stat)
    );

    dmc_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .dp_cmd     (dp_cmd),
        .dp_stat    (dp_stat),
        .cfg_write  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .command    (command),
        .random_dir (random_dir),
        .read_col   (read_col),
        .read_row   (read_row),
        .status     (status),
        .cell_col   (cell_col),
        .cell_row   (cell_row),
        .cell_open  (cell_open)
    );

endmodule

`default_nettype wire

>>> tb/testbench.sv
// self-checking testbench for dfs_maze_carver_unit: directed and random command streams
// with its own maze predictor, bursty sender and stalling receiver
// depends on dmc_pkg and dfs_maze_carver_unit
`default_nettype none

module testbench;
    import dmc_pkg::*;

    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
    localparam int QUIET_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 8;
    localparam int RANDOM_ITEMS = 600;
    localparam int HOLD_CYCLES  = 300;
    localparam int GRID_SIDE    = 64;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [DIR_W-1:0]   dir;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } maze_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COORD_W-1:0]  col;
        logic [COORD_W-1:0]  row;
        logic                open;
    } maze_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [CMD_W-1:0]     command = CMD_INIT;
    logic [DIR_W-1:0]     random_dir = DIR_RIGHT;
    logic [COORD_W-1:0]   read_col = '0;
    logic [COORD_W-1:0]   read_row = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic [COORD_W-1:0]   cell_col;
    logic [COORD_W-1:0]   cell_row;
    logic                 cell_open;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_GRID_COLS;
    logic [SIZE_W-1:0]    cfg_data = GRID_RESET;

    dfs_maze_carver_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .random_dir(random_dir),
        .read_col  (read_col),
        .read_row  (read_row),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cell_col  (cell_col),
        .cell_row  (cell_row),
        .cell_open (cell_open),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic                grid_open   [GRID_SIDE][GRID_SIDE];
    logic [DIRSET_W-1:0] grid_dirs   [GRID_SIDE][GRID_SIDE];
    logic [DIR_W-1:0]    grid_back   [GRID_SIDE][GRID_SIDE];
    logic                grid_linked [GRID_SIDE][GRID_SIDE];
    logic [COORD_W-1:0]  node_col = START_POS;
    logic [COORD_W-1:0]  node_row = START_POS;
    logic                maze_done = 1'b0;
    logic [SIZE_W-1:0]   size_cols = GRID_RESET;
    logic [SIZE_W-1:0]   size_rows = GRID_RESET;

    maze_cmd_t cmd_queue[$];
    maze_res_t expected_moves[$];
    maze_cmd_t held_cmd;
    logic      in_flight = 1'b0;

    int err_cnt = 0;
    int results_seen = 0;
    int gap_left = 0;
    int burst_left = 1;
    int quiet_cycles = 0;

    function automatic maze_res_t make_res(logic [STATUS_W-1:0] st, int c, int r, logic op);
        maze_res_t res;
        res.status = st;
        res.col = c[COORD_W-1:0];
        res.row = r[COORD_W-1:0];
        res.open = op;
        return res;
    endfunction

    function automatic int used_size(logic [SIZE_W-1:0] v);
        return (int'(v) > GRID_SIDE) ? GRID_SIDE : int'(v);
    endfunction

    function automatic maze_res_t maze_step(logic [DIR_W-1:0] dir);
        int c, r, nc, nr, cols, rows, wc, wr;
        logic [DIRSET_W-1:0] dirs, bitm;
        logic ok;
        maze_res_t res;
        c = int'(node_col);
        r = int'(node_row);
        nc = c;
        nr = r;
        ok = 1'b0;
        cols = used_size(size_cols);
        rows = used_size(size_rows);
        if (maze_done)
            res = make_res(ST_FINISHED, c, r, 1'b0);
        else
        begin
            dirs = grid_dirs[r][c];
            if (dirs == '0)
            begin
                if (!(c == int'(START_POS) && r == int'(START_POS)))
                begin
                    case (grid_back[r][c])
                        DIR_RIGHT: nc = c + 2;
                        DIR_DOWN:  nr = r + 2;
                        DIR_LEFT:  nc = c - 2;
                        default:   nr = r - 2;
                    endcase
                    nc = nc & 63;
                    nr = nr & 63;
                end
                if (nc == int'(START_POS) && nr == int'(START_POS))
                begin
                    node_col = START_POS;
                    node_row = START_POS;
                    maze_done = 1'b1;
                    res = make_res(ST_FINISHED, int'(START_POS), int'(START_POS), 1'b0);
                end
                else
                begin
                    node_col = nc[COORD_W-1:0];
                    node_row = nr[COORD_W-1:0];
                    res = make_res(ST_BACKTRACKED, nc, nr, 1'b0);
                end
            end
            else
            begin
                bitm = 4'b0001 << dir;
                if ((dirs & bitm) == '0)
                    res = make_res(ST_EXPLORED, c, r, 1'b0);
                else
                begin
                    grid_dirs[r][c] = dirs & ~bitm;
                    case (dir)
                        DIR_RIGHT: if (c + 2 < cols) begin nc = c + 2; ok = 1'b1; end
                        DIR_DOWN:  if (r + 2 < rows) begin nr = r + 2; ok = 1'b1; end
                        DIR_LEFT:  if (c >= 2) begin nc = c - 2; ok = 1'b1; end
                        default:   if (r >= 2) begin nr = r - 2; ok = 1'b1; end
                    endcase
                    if (!ok || !grid_open[nr][nc] || grid_linked[nr][nc])
                        res = make_res(ST_BLOCKED, c, r, 1'b0);
                    else
                    begin
                        grid_linked[nr][nc] = 1'b1;
                        grid_back[nr][nc] = dir ^ DIR_FLIP;
                        wc = (c + nc) / 2;
                        wr = (r + nr) / 2;
                        grid_open[wr][wc] = 1'b1;
                        node_col = nc[COORD_W-1:0];
                        node_row = nr[COORD_W-1:0];
                        res = make_res(ST_CARVED, wc, wr, 1'b0);
                    end
                end
            end
        end
        return res;
    endfunction

    function automatic void predict_maze_cmd(maze_cmd_t it);
        int cols, rows;
        cols = used_size(size_cols);
        rows = used_size(size_rows);
        case (it.cmd)
            CMD_INIT:
            begin
                for (int r = 0; r < GRID_SIDE; r++)
                    for (int c = 0; c < GRID_SIDE; c++)
                    begin
                        grid_open[r][c] = (c < cols) && (r < rows) && c[0] && r[0];
                        grid_dirs[r][c] = ALL_DIRS;
                        grid_linked[r][c] = 1'b0;
                        grid_back[r][c] = DIR_RIGHT;
                    end
                grid_linked[START_POS][START_POS] = 1'b1;
                node_col = START_POS;
                node_row = START_POS;
                maze_done = 1'b0;
                expected_moves.push_back(make_res(ST_INIT_DONE, int'(START_POS),
                                                  int'(START_POS), 1'b0));
            end
            CMD_STEP:
                expected_moves.push_back(maze_step(it.dir));
            CMD_READ:
                expected_moves.push_back(make_res(ST_READ_DATA, int'(it.col), int'(it.row),
                                                  grid_open[it.row][it.col]));
            default:
            begin
            end
        endcase
    endfunction

    function automatic void add_cmd(logic [CMD_W-1:0] cmd, logic [DIR_W-1:0] dir,
                                    logic [COORD_W-1:0] c, logic [COORD_W-1:0] r);
        maze_cmd_t it;
        it.cmd = cmd;
        it.dir = dir;
        it.col = c;
        it.row = r;
        cmd_queue.push_back(it);
    endfunction

    function automatic int pick_size();
        int k;
        k = $urandom_range(0, 11);
        if (k == 0)
            return 64;
        if (k == 1)
            return 2;
        if (k == 2)
            return $urandom_range(11, 64);
        return $urandom_range(3, 10);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got, want);
        err_cnt++;
    endtask

    task automatic wait_idle();
        while (cmd_queue.size() != 0 || in_flight || expected_moves.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(int cols, int rows);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_GRID_COLS;
        cfg_data <= cols[SIZE_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        size_cols = cols[SIZE_W-1:0];
        cfg_index <= CFG_GRID_ROWS;
        cfg_data <= rows[SIZE_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        size_rows = rows[SIZE_W-1:0];
        cfg_valid <= 1'b0;
    endtask

    // sender: bursts with gaps
    always @(posedge clk)
    begin : drive_proc
        logic offer;
        offer = 1'b0;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predict_maze_cmd(held_cmd);
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (cmd_queue.size() != 0)
                begin
                    held_cmd = cmd_queue.pop_front();
                    offer = 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                                                 : $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                in_valid <= offer;
                in_flight = offer;
                if (offer)
                begin
                    command <= held_cmd.cmd;
                    random_dir <= held_cmd.dir;
                    read_col <= held_cmd.col;
                    read_row <= held_cmd.row;
                end
            end
        end
    end

    // receiver: stall pattern plus one long hold-off
    always @(posedge clk)
    begin : accept_proc
        int mode;
        int mode_left;
        int hold_left;
        logic hold_done;
        logic toggle;
        logic rdy;
        if (!rst_n)
        begin
            mode = 0;
            mode_left = 0;
            hold_left = 0;
            hold_done = 1'b0;
            toggle = 1'b0;
            out_ready <= 1'b0;
        end
        else
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (!hold_done && results_seen >= 100 && cmd_queue.size() > 30)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
                rdy = 1'b0;
            end
            else
            begin
                if (mode_left <= 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(1, 60);
                end
                mode_left--;
                toggle = !toggle;
                case (mode)
                    0: rdy = 1'b1;
                    1: rdy = 1'($urandom_range(0, 1));
                    2: rdy = ($urandom_range(0, 3) == 0);
                    default: rdy = toggle;
                endcase
            end
            out_ready <= rdy;
        end
    end

    // result checker
    always @(posedge clk)
    begin : check_proc
        maze_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_moves.size() == 0)
                report_mismatch("status of unexpected transaction", int'(status), -1);
            else
            begin
                want = expected_moves.pop_front();
                if (status !== want.status)
                    report_mismatch("status", int'(status), int'(want.status));
                if (cell_col !== want.col)
                    report_mismatch("cell_col", int'(cell_col), int'(want.col));
                if (cell_row !== want.row)
                    report_mismatch("cell_row", int'(cell_row), int'(want.row));
                if (cell_open !== want.open)
                    report_mismatch("cell_open", int'(cell_open), int'(want.open));
            end
            results_seen++;
        end
    end

    // watchdog on channel activity
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("dfs_maze_carver_unit regression: fail");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int produced, seq, cols, rows, nodes, steps, k;
        logic skip_init;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        wait_idle();

        // smallest grid: start node boxed in, every direction blocked, then finished
        write_size(2, 2);
        add_cmd(CMD_INIT, DIR_UP, 6'd63, 6'd63);
        add_cmd(CMD_STEP, DIR_RIGHT, '0, '0);
        add_cmd(CMD_STEP, DIR_DOWN, '0, '0);
        add_cmd(CMD_STEP, DIR_LEFT, '0, '0);
        add_cmd(CMD_STEP, DIR_UP, '0, '0);
        add_cmd(CMD_STEP, DIR_RIGHT, '0, '0);
        add_cmd(CMD_READ, DIR_RIGHT, START_POS, START_POS);
        add_cmd(CMD_READ, DIR_UP, 6'd63, 6'd63);
        add_cmd(CMD_NOP, DIR_UP, 6'd63, 6'd63);
        wait_idle();

        // largest grid: carve, linked node, explored direction, border
        write_size(64, 64);
        add_cmd(CMD_INIT, DIR_RIGHT, '0, '0);
        add_cmd(CMD_STEP, DIR_RIGHT, '0, '0);
        add_cmd(CMD_STEP, DIR_RIGHT, '0, '0);
        add_cmd(CMD_STEP, DIR_LEFT, '0, '0);
        add_cmd(CMD_STEP, DIR_LEFT, '0, '0);
        add_cmd(CMD_STEP, DIR_UP, '0, '0);
        add_cmd(CMD_READ, DIR_LEFT, 6'd2, START_POS);
        add_cmd(CMD_READ, DIR_DOWN, 6'd63, 6'd63);
        add_cmd(CMD_READ, DIR_DOWN, 6'd0, 6'd63);
        wait_idle();

        // grid widened after init: wall destination, then backtrack to start
        write_size(4, 2);
        add_cmd(CMD_INIT, DIR_RIGHT, '0, '0);
        add_cmd(CMD_STEP, DIR_RIGHT, '0, '0);
        wait_idle();
        write_size(64, 2);
        add_cmd(CMD_STEP, DIR_RIGHT, '0, '0);
        add_cmd(CMD_STEP, DIR_UP, '0, '0);
        add_cmd(CMD_STEP, DIR_DOWN, '0, '0);
        add_cmd(CMD_STEP, DIR_LEFT, '0, '0);
        add_cmd(CMD_STEP, DIR_RIGHT, '0, '0);
        add_cmd(CMD_STEP, DIR_DOWN, '0, '0);
        wait_idle();

        // random mazes, each a size setting, an init unless skipped, then mostly steps
        produced = 0;
        seq = 0;
        while (produced < RANDOM_ITEMS)
        begin
            cols = pick_size();
            rows = pick_size();
            skip_init = (seq > 0) && ($urandom_range(0, 4) == 0);
            wait_idle();
            write_size(cols, rows);
            if (!skip_init)
            begin
                add_cmd(CMD_INIT, DIR_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
                produced++;
            end
            nodes = (cols / 2) * (rows / 2);
            steps = nodes * 12 + 6;
            if (steps > 160)
                steps = 160;
            for (int i = 0; i < steps; i++)
            begin
                k = $urandom_range(0, 39);
                if (k < 4)
                begin
                    if ($urandom_range(0, 1))
                        add_cmd(CMD_READ, DIR_W'($urandom),
                                COORD_W'($urandom_range(0, cols - 1)),
                                COORD_W'($urandom_range(0, rows - 1)));
                    else
                        add_cmd(CMD_READ, DIR_W'($urandom), COORD_W'($urandom),
                                COORD_W'($urandom));
                    produced++;
                end
                else if (k < 6)
                    add_cmd(CMD_NOP, DIR_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
                else if (k == 6 && $urandom_range(0, 3) == 0)
                begin
                    add_cmd(CMD_INIT, DIR_W'($urandom), COORD_W'($urandom),
                            COORD_W'($urandom));
                    produced++;
                end
                else
                begin
                    add_cmd(CMD_STEP, DIR_W'($urandom), COORD_W'($urandom),
                            COORD_W'($urandom));
                    produced++;
                end
            end
            seq++;
        end

        wait_idle();
        if (err_cnt == 0)
            $display("dfs_maze_carver_unit regression: pass");
        else
            $display("dfs_maze_carver_unit regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
hw/rtl/dmc_pkg.sv
hw/rtl/dmc_ctrl.sv
hw/rtl/dmc_datapath.sv
hw/rtl/dfs_maze_carver_unit.sv
tb/testbench.sv
